>>> src/mrc_pkg.sv
// mrc_pkg: shared types, constants and the CRC-16 byte step for the
// Modbus RTU response checker. No dependencies.
`default_nettype none

package mrc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } byte_item_t;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic [15:0] value_tenths;
  } result_item_t;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [15:0] LIMIT_RESET = 16'd10000;

  // Frame positions
  localparam logic [2:0] POS_ADDR     = 3'd0;
  localparam logic [2:0] POS_FUNC     = 3'd1;
  localparam logic [2:0] POS_COUNT    = 3'd2;
  localparam logic [2:0] POS_VALUE_HI = 3'd3;
  localparam logic [2:0] POS_VALUE_LO = 3'd4;
  localparam logic [2:0] POS_CRC_LO   = 3'd5;
  localparam logic [2:0] POS_CRC_HI   = 3'd6;
  localparam logic [2:0] POS_UNUSED   = 3'd7;

  // Status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERR   = 2'd1;
  localparam logic [1:0] STATUS_RANGE_ERR = 2'd2;

  // Reflected CRC-16, one byte: eight shift/xor steps.
  function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/mrc_frame_engine.sv
// mrc_frame_engine: input register, frame position counter, running CRC,
// value capture and end-of-frame check. Depends on mrc_pkg.
`default_nettype none

module mrc_frame_engine (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  byte_valid,
  output logic                       byte_stall,
  input  wire mrc_pkg::byte_item_t   byte_item,
  input  wire logic [15:0]           value_limit,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output mrc_pkg::result_item_t      res_item
);

  logic                 stage_valid;
  mrc_pkg::byte_item_t  stage_item;

  logic [2:0]  byte_index;
  logic [15:0] running_crc;
  logic [15:0] value_hold;
  logic [7:0]  crc_low_hold;

  logic [2:0]  pos;
  logic [15:0] crc_base;
  logic [15:0] crc_next;
  logic [15:0] rx_crc;
  logic        consume;
  logic        stage_load;

  // A stray index of seven, or the start flag, restarts at byte 0.
  assign pos = (stage_item.frame_start || byte_index == mrc_pkg::POS_UNUSED)
               ? mrc_pkg::POS_ADDR : byte_index;

  assign crc_base = (pos == mrc_pkg::POS_ADDR) ? mrc_pkg::CRC_INIT : running_crc;
  assign crc_next = mrc_pkg::crc_step(crc_base, stage_item.data_byte);
  assign rx_crc   = {stage_item.data_byte, crc_low_hold};

  assign res_valid  = stage_valid && (pos == mrc_pkg::POS_CRC_HI);
  assign consume    = stage_valid && (!res_valid || res_ready);
  assign byte_stall = stage_valid && !consume;
  assign stage_load = !stage_valid || consume;

  always_comb begin
    res_item.value_tenths = value_hold;
    if (rx_crc != running_crc) begin
      res_item.frame_status = mrc_pkg::STATUS_CRC_ERR;
    end else if (value_hold > value_limit) begin
      res_item.frame_status = mrc_pkg::STATUS_RANGE_ERR;
    end else begin
      res_item.frame_status = mrc_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_load && byte_valid) begin
      stage_item <= byte_item;
    end
    if (rst) begin
      stage_valid  <= 1'b0;
      byte_index   <= mrc_pkg::POS_ADDR;
      running_crc  <= mrc_pkg::CRC_INIT;
      value_hold   <= 16'h0000;
      crc_low_hold <= 8'h00;
    end else begin
      if (stage_load) begin
        stage_valid <= byte_valid;
      end
      if (consume) begin
        unique case (pos)
          mrc_pkg::POS_ADDR, mrc_pkg::POS_FUNC, mrc_pkg::POS_COUNT: begin
            running_crc <= crc_next;
            byte_index  <= pos + 3'd1;
          end
          mrc_pkg::POS_VALUE_HI: begin
            running_crc      <= crc_next;
            value_hold[15:8] <= stage_item.data_byte;
            byte_index       <= pos + 3'd1;
          end
          mrc_pkg::POS_VALUE_LO: begin
            running_crc     <= crc_next;
            value_hold[7:0] <= stage_item.data_byte;
            byte_index      <= pos + 3'd1;
          end
          mrc_pkg::POS_CRC_LO: begin
            crc_low_hold <= stage_item.data_byte;
            byte_index   <= mrc_pkg::POS_CRC_HI;
          end
          default: begin
            byte_index  <= mrc_pkg::POS_ADDR;
            running_crc <= mrc_pkg::CRC_INIT;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> src/mrc_result_reg.sv
// mrc_result_reg: output register holding one result until transferred.
// Depends on mrc_pkg.
`default_nettype none

module mrc_result_reg (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   res_valid,
  output logic                        res_ready,
  input  wire mrc_pkg::result_item_t  res_item,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output mrc_pkg::result_item_t       result_item
);

  assign res_ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      result_item <= res_item;
    end
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_ready) begin
      result_valid <= res_valid;
    end
  end

endmodule

`default_nettype wire

>>> src/modbus_response_checker_top.sv
// modbus_response_checker_top: Modbus RTU single-register response checker.
// Depends on mrc_pkg, mrc_frame_engine and mrc_result_reg.
//
// Feed the seven response bytes (address, function, byte count, value high,
// value low, CRC low, CRC high) one byte per transfer on the byte channel.
// Bytes are taken one per cycle while byte_stall is low; the full CRC-16 byte
// update (reflected, init 0xFFFF, poly 0xA001) is done combinationally between
// the input register and the frame state. After the seventh byte has passed
// the input register and the result register, one result appears on the
// result channel: status OK, CRC mismatch (takes precedence) or value above
// value_limit, together with the raw big-endian value in tenths. Bytes that
// cause no result never wait on the result side; the input stalls only when
// a final byte meets a result that is still held. frame_start forces the
// byte to be treated as byte 0. value_limit resets to 10000; the user writes it
// via cfg_wr_en/cfg_wr_data while the block is idle, which it does not enforce.
`default_nettype none

module modbus_response_checker_top (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   byte_valid,
  output logic                        byte_stall,
  input  wire mrc_pkg::byte_item_t    byte_item,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output mrc_pkg::result_item_t       result_item,
  input  wire logic                   cfg_wr_en,
  input  wire logic [15:0]            cfg_wr_data
);

  logic [15:0]            value_limit;
  logic                   res_valid;
  logic                   res_ready;
  mrc_pkg::result_item_t  res_item;

  // Limit register, reset wins over a write
  always_ff @(posedge clk) begin
    if (rst) begin
      value_limit <= mrc_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      value_limit <= cfg_wr_data;
    end
  end

  mrc_frame_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_item   (byte_item),
    .value_limit (value_limit),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_item    (res_item)
  );

  mrc_result_reg u_result (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_item     (res_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  // The input only backs up behind a result that is being held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> (result_valid && result_stall))
    else $error("byte channel stalled without a held result");

  // Status code three is never produced
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_item.frame_status != 2'd3))
    else $error("undefined frame status");

  // Limit comes out of reset at its default
  a_limit_reset: assert property (@(posedge clk)
    rst |=> (value_limit == mrc_pkg::LIMIT_RESET))
    else $error("value limit not at reset value");

endmodule

`default_nettype wire

>>> tb/sv/modbus_response_checker_top_tb.sv
// modbus_response_checker_top_tb: self-checking bench for the Modbus RTU response checker.
// Tracks frame position, CRC-16, captured value and limit locally, and compares each result.
// Depends on mrc_pkg and modbus_response_checker_top.
`default_nettype none

module modbus_response_checker_top_tb;

  // Pipeline is input register, frame state, result register: SETTLE_CYCLES
  // covers any byte still in flight once the last result has gone out.
  localparam int SETTLE_CYCLES = 8;
  // Longest run of cycles with no transfer on either channel. A correct run
  // sees at most a short sender gap plus a receiver stall streak, or a settle
  // pause, so this is many times the worst case.
  localparam int QUIET_LIMIT   = 2000;
  localparam int REPORT_MAX    = 10;

  // Modbus read function codes used in plausible headers
  localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FUNC_READ_INPUT   = 8'h04;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  byte_valid = 1'b0;
  logic                  byte_stall;
  mrc_pkg::byte_item_t   byte_item = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  mrc_pkg::result_item_t result_item;
  logic                  cfg_wr_en = 1'b0;
  logic [15:0]           cfg_wr_data = '0;

  modbus_response_checker_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Local copy of the frame tracker: position, running CRC, captured value,
  // CRC low byte and the limit register.
  // ---------------------------------------------------------------------------
  logic [2:0]   frame_pos   = mrc_pkg::POS_ADDR;
  logic [15:0]  frame_crc   = mrc_pkg::CRC_INIT;
  logic [15:0]  frame_value = '0;
  logic [7:0]   frame_crc_lo = '0;
  logic [15:0]  value_limit = mrc_pkg::LIMIT_RESET;

  mrc_pkg::result_item_t expected_results[$];

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int bytes_sent     = 0;
  int send_gap_pct   = 0;
  int stall_pct      = 0;
  logic force_start  = 1'b0;

  // Reflected CRC-16, done as a bit-serial LFSR: feedback is the low CRC bit
  // against the incoming data bit, least significant bit first.
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ mrc_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  // Advance the tracker by one accepted byte; the last byte of a frame
  // queues the expected result.
  task automatic track_frame_byte(input logic [7:0] b, input logic start);
    logic [2:0]            pos;
    mrc_pkg::result_item_t r;
    pos = start ? mrc_pkg::POS_ADDR : frame_pos;
    if (pos == mrc_pkg::POS_UNUSED) begin
      pos = mrc_pkg::POS_ADDR;
    end
    unique case (pos)
      mrc_pkg::POS_CRC_LO: begin
        frame_crc_lo = b;
        frame_pos    = mrc_pkg::POS_CRC_HI;
      end
      mrc_pkg::POS_CRC_HI: begin
        r.value_tenths = frame_value;
        // CRC fault wins over the range check
        if ({b, frame_crc_lo} != frame_crc) begin
          r.frame_status = mrc_pkg::STATUS_CRC_ERR;
        end else if (frame_value > value_limit) begin
          r.frame_status = mrc_pkg::STATUS_RANGE_ERR;
        end else begin
          r.frame_status = mrc_pkg::STATUS_OK;
        end
        expected_results.push_back(r);
        frame_pos = mrc_pkg::POS_ADDR;
        frame_crc = mrc_pkg::CRC_INIT;
      end
      default: begin
        frame_crc = crc16_update((pos == mrc_pkg::POS_ADDR) ? mrc_pkg::CRC_INIT : frame_crc, b);
        if (pos == mrc_pkg::POS_VALUE_HI) begin
          frame_value[15:8] = b;
        end else if (pos == mrc_pkg::POS_VALUE_LO) begin
          frame_value[7:0] = b;
        end
        frame_pos = pos + 3'd1;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, and the check of every result transfer
  // against the oldest expectation. Inputs and outputs are both sampled at
  // the rising edge, before any nonblocking update of that edge lands.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  mrc_pkg::result_item_t oldest;

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          if (mismatch_count < REPORT_MAX) begin
            $display("mismatch: unexpected result status %0d value %0d",
                     result_item.frame_status, result_item.value_tenths);
          end
          mismatch_count++;
        end else begin
          oldest = expected_results.pop_front();
          if (result_item.frame_status !== oldest.frame_status) begin
            if (mismatch_count < REPORT_MAX) begin
              $display("mismatch: frame_status expected %0d got %0d (value %0d)",
                       oldest.frame_status, result_item.frame_status, oldest.value_tenths);
            end
            mismatch_count++;
          end
          if (result_item.value_tenths !== oldest.value_tenths) begin
            if (mismatch_count < REPORT_MAX) begin
              $display("mismatch: value_tenths expected %0d got %0d",
                       oldest.value_tenths, result_item.value_tenths);
            end
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
    end
    $display("modbus_response_checker_top_tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Byte side
  // ---------------------------------------------------------------------------

  // One byte transfer. Idle cycles may come first, each with the gap
  // percentage; valid then stays high and the payload is held until the
  // block takes it.
  task automatic send_byte(input logic [7:0] b, input logic start);
    mrc_pkg::byte_item_t it;
    while ($urandom_range(99) < send_gap_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    it.data_byte   = b;
    it.frame_start = start;
    byte_item  <= it;
    byte_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (byte_stall);
    track_frame_byte(b, start);
    bytes_sent++;
  endtask

  // Sender holds off until every queued result is out, then lets bytes that
  // make no result drain through the pipeline.
  task automatic wait_for_results();
    byte_valid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Limit writes only happen with the block idle.
  task automatic set_value_limit(input logic [15:0] v);
    wait_for_results();
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    value_limit = v;
  endtask

  // Seven-byte response with a correct CRC appended, low byte first.
  function automatic logic [6:0][7:0] build_frame(
      input logic [7:0] addr, input logic [7:0] func,
      input logic [7:0] count, input logic [15:0] value);
    logic [6:0][7:0] f;
    logic [15:0]     c;
    f[0] = addr;
    f[1] = func;
    f[2] = count;
    f[3] = value[15:8];
    f[4] = value[7:0];
    c = mrc_pkg::CRC_INIT;
    for (int k = 0; k < 5; k++) begin
      c = crc16_update(c, f[k]);
    end
    f[5] = c[7:0];
    f[6] = c[15:8];
    return f;
  endfunction

  // Send the first len bytes; only byte 0 can carry the start flag.
  task automatic send_frame(input logic [6:0][7:0] f, input int len, input logic start);
    for (int k = 0; k < len; k++) begin
      send_byte(f[k], (k == 0) ? start : 1'b0);
    end
  endtask

  // Values biased towards the limit edge and the field extremes.
  function automatic logic [15:0] pick_value();
    unique case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return value_limit + 16'($urandom_range(4)) - 16'd2;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // Random but mostly plausible header: slave address, read function, count 2.
  function automatic logic [6:0][7:0] random_frame(input logic [15:0] value);
    logic [7:0] addr, func, count;
    addr  = ($urandom_range(9) < 8) ? 8'($urandom_range(1, 247)) : 8'($urandom_range(255));
    func  = ($urandom_range(9) < 8)
            ? (($urandom_range(1) == 0) ? FUNC_READ_HOLDING : FUNC_READ_INPUT)
            : 8'($urandom_range(255));
    count = ($urandom_range(9) < 8) ? 8'h02 : 8'($urandom_range(255));
    return build_frame(addr, func, count, value);
  endfunction

  // Start flag for a well-formed frame: forced after noise or a cut frame,
  // otherwise random so that back-to-back frames without it are exercised.
  function automatic logic next_start();
    logic s;
    s = force_start | ($urandom_range(1) == 1);
    force_start = 1'b0;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset limit 10000: value on the limit passes; the next frame follows
  // without the start flag and has both a bad CRC and a value above limit.
  task automatic test_status_codes();
    logic [6:0][7:0] f;
    f = build_frame(8'h00, FUNC_READ_HOLDING, 8'h02, 16'd10000);
    send_frame(f, 7, 1'b1);
    f = build_frame(8'h01, FUNC_READ_HOLDING, 8'h02, 16'd10001);
    f[6] = f[6] ^ 8'h80;
    send_frame(f, 7, 1'b0);
  endtask

  // A frame cut after three bytes, then a resynchronising start flag on a
  // frame with all-ones header and value: out of range.
  task automatic test_resync();
    logic [6:0][7:0] f;
    f = build_frame(8'h11, FUNC_READ_HOLDING, 8'h02, 16'h1234);
    send_frame(f, 3, 1'b1);
    f = build_frame(8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    send_frame(f, 7, 1'b1);
  endtask

  // Limit at both ends of its range.
  task automatic test_limit_extremes();
    set_value_limit(16'h0000);
    send_frame(random_frame(16'h0000), 7, 1'b1);
    send_frame(random_frame(16'h0001), 7, next_start());
    repeat (8) send_frame(random_frame(pick_value()), 7, next_start());
    set_value_limit(16'hFFFF);
    send_frame(random_frame(16'hFFFF), 7, next_start());
    repeat (9) send_frame(random_frame(pick_value()), 7, next_start());
  endtask

  // Mostly well-formed frames with random content; the rest corrupted CRCs,
  // cut frames and loose noise bytes with random start flags. Part way
  // through, the sender waits for every outstanding result.
  task automatic test_random_traffic(input int n_bytes, input int gap_pct, input int hold_pct);
    logic [6:0][7:0] f;
    int              first;
    int              kind;
    logic            paused;
    send_gap_pct = gap_pct;
    stall_pct    = hold_pct;
    set_value_limit(($urandom_range(1) == 0) ? mrc_pkg::LIMIT_RESET
                                             : 16'($urandom_range(65535)));
    first  = bytes_sent;
    paused = 1'b0;
    while (bytes_sent - first < n_bytes) begin
      if (!paused && (bytes_sent - first > n_bytes / 2)) begin
        wait_for_results();
        paused = 1'b1;
      end
      kind = $urandom_range(99);
      f = random_frame(pick_value());
      if (kind < 75) begin
        send_frame(f, 7, next_start());
      end else if (kind < 87) begin
        // damage one bit anywhere in the frame after the CRC was worked out
        f[$urandom_range(6)][$urandom_range(7)] ^= 1'b1;
        send_frame(f, 7, next_start());
      end else if (kind < 94) begin
        send_frame(f, $urandom_range(1, 6), next_start());
        force_start = 1'b1;
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_byte(8'($urandom_range(255)), ($urandom_range(3) == 0));
        end
        force_start = 1'b1;
      end
    end
  endtask

  initial begin
    send_gap_pct = 21;
    stall_pct    = 48;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_status_codes();
    test_resync();
    test_limit_extremes();
    test_random_traffic(165, 21, 48);
    test_random_traffic(165, 48, 21);
    test_random_traffic(165, 0, 0);

    wait_for_results();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("modbus_response_checker_top_tb: PASS");
    end else begin
      $display("modbus_response_checker_top_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
